/* hw/rtl/unpm_pkg.sv */
// ----------------------------------------------------------------------------
// unpm_pkg
// Shared types, constants and the divider step for the unpremultiply block.
// ----------------------------------------------------------------------------
package unpm_pkg;

  localparam logic [7:0] FULL_SCALE = 8'd255;

  // source byte order
  localparam logic LAYOUT_BGRA = 1'b0;
  localparam logic LAYOUT_ARGB = 1'b1;

  // divider stages, two quotient bits each
  localparam int DIV_STAGES = 4;
  localparam int BITS_PER_STAGE = 2;

  // pipeline registers between input transfer and result strobe
  localparam int LATENCY = DIV_STAGES + 2;

  // one colour channel in flight through the divider
  typedef struct packed {
    logic [7:0] rem;   // partial remainder, always below alpha when not saturated
    logic [7:0] low;   // dividend bits not yet shifted in, msb first
    logic [7:0] quo;   // quotient bits so far
    logic       sat;   // channel at or above alpha
  } lane_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  alpha;
    lane_t [2:0] ch;   // 2 = red, 1 = green, 0 = blue
  } stage_t;

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nb,
                                          input logic [7:0] den);
    logic [8:0] t;
    logic [8:0] diff;
    t = {rem, nb};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      return {1'b1, diff[7:0]};
    end else begin
      return {1'b0, t[7:0]};
    end
  endfunction

  // final byte from a finished lane
  function automatic logic [7:0] lane_result(input lane_t ln, input logic [7:0] alpha);
    if (alpha == 8'd0) begin
      return 8'd0;
    end else if (ln.sat) begin
      return FULL_SCALE;
    end else begin
      return ln.quo;
    end
  endfunction

endpackage

/* hw/rtl/unpremultiply_alpha_pixel.sv */
// ----------------------------------------------------------------------------
// unpremultiply_alpha_pixel
// Recovers straight alpha, one 32-bit premultiplied pixel per cycle unless busy:
// colour = colour * 255 / alpha, truncated, saturated at 255, zero at zero alpha.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   handshake
//  -------   ---------------------------------------   ---------------------------
//  input     byte_zero..byte_three                     start && !busy
//  result    red_out, green_out, blue_out, alpha_out   strobe, one cycle
//  config    cfg_data (source layout)                  cfg_we
//
// One pixel enters every cycle while busy is low. Each result passes through the
// pipeline: one stage for byte selection, one for the x255 product, and four
// stages of a restoring divider, two quotient bits each.
// busy is high only during reset; reset clears the register and all valid bits.
// The receiver cannot stall, so the pipeline never holds.
//
module unpremultiply_alpha_pixel
  import unpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] byte_zero,
  input  logic [7:0] byte_one,
  input  logic [7:0] byte_two,
  input  logic [7:0] byte_three,
  input  logic       cfg_we,
  input  logic       cfg_data,
  output logic       strobe,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic [7:0] alpha_out
);

  logic       source_layout;
  logic       in_xfer;

  // selection stage
  logic       sel_valid;
  logic [7:0] sel_alpha;
  logic [7:0] sel_red;
  logic [7:0] sel_green;
  logic [7:0] sel_blue;

  stage_t     pre;
  stage_t     pre_next;
  stage_t     div [DIV_STAGES];
  stage_t     div_next [DIV_STAGES];

  assign busy    = rst;
  assign in_xfer = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_layout <= LAYOUT_BGRA;
    end else if (cfg_we) begin
      source_layout <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
    end else begin
      sel_valid <= in_xfer;
    end
    unique case (source_layout)
      LAYOUT_BGRA: begin
        sel_blue  <= byte_zero;
        sel_green <= byte_one;
        sel_red   <= byte_two;
        sel_alpha <= byte_three;
      end
      LAYOUT_ARGB: begin
        sel_alpha <= byte_zero;
        sel_red   <= byte_one;
        sel_green <= byte_two;
        sel_blue  <= byte_three;
      end
      default: begin
        sel_alpha <= byte_three;
        sel_red   <= byte_two;
        sel_green <= byte_one;
        sel_blue  <= byte_zero;
      end
    endcase
  end

  // x255 product; its high byte is below alpha whenever the channel is
  always_comb begin
    logic [7:0]  chans [3];
    logic [15:0] prod;
    chans[2] = sel_red;
    chans[1] = sel_green;
    chans[0] = sel_blue;
    pre_next.valid = sel_valid;
    pre_next.alpha = sel_alpha;
    for (int c = 0; c < 3; c++) begin
      prod = {chans[c], 8'h00} - {8'h00, chans[c]};
      pre_next.ch[c].rem = prod[15:8];
      pre_next.ch[c].low = prod[7:0];
      pre_next.ch[c].quo = 8'd0;
      pre_next.ch[c].sat = (chans[c] >= sel_alpha);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre.valid <= 1'b0;
    end else begin
      pre.valid <= pre_next.valid;
    end
    pre.alpha <= pre_next.alpha;
    pre.ch    <= pre_next.ch;
  end

  // divider stages
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    stage_t src;
    if (s == 0) begin : g_first
      assign src = pre;
    end else begin : g_rest
      assign src = div[s-1];
    end

    always_comb begin
      logic [8:0] step;
      div_next[s] = src;
      for (int c = 0; c < 3; c++) begin
        for (int b = 0; b < BITS_PER_STAGE; b++) begin
          step = div_step(div_next[s].ch[c].rem, div_next[s].ch[c].low[7], src.alpha);
          div_next[s].ch[c].rem = step[7:0];
          div_next[s].ch[c].low = {div_next[s].ch[c].low[6:0], 1'b0};
          div_next[s].ch[c].quo = {div_next[s].ch[c].quo[6:0], step[8]};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div[s].valid <= 1'b0;
      end else begin
        div[s].valid <= div_next[s].valid;
      end
      div[s].alpha <= div_next[s].alpha;
      div[s].ch    <= div_next[s].ch;
    end
  end

  assign strobe    = div[DIV_STAGES-1].valid;
  assign alpha_out = div[DIV_STAGES-1].alpha;
  assign red_out   = lane_result(div[DIV_STAGES-1].ch[2], div[DIV_STAGES-1].alpha);
  assign green_out = lane_result(div[DIV_STAGES-1].ch[1], div[DIV_STAGES-1].alpha);
  assign blue_out  = lane_result(div[DIV_STAGES-1].ch[0], div[DIV_STAGES-1].alpha);

endmodule

/* hw/rtl/unpm_checker.sv */
// ----------------------------------------------------------------------------
// unpm_checker
// Port-level checks for unpremultiply_alpha_pixel, bound into that module.
// ----------------------------------------------------------------------------
module unpm_checker
  import unpm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [7:0] byte_zero,
  input logic [7:0] byte_three,
  input logic       cfg_we,
  input logic       cfg_data,
  input logic       strobe,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out,
  input logic [7:0] alpha_out
);

  logic       layout;
  logic [7:0] alpha_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      layout <= LAYOUT_BGRA;
    end else if (cfg_we) begin
      layout <= cfg_data;
    end
  end

  assign alpha_in = (layout == LAYOUT_ARGB) ? byte_zero : byte_three;

  // every transfer gives exactly one result at fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    strobe == $past(start && !busy, LATENCY))
    else $error("result strobe does not match input transfer");

  // alpha comes through from the layout's alpha byte
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    strobe |-> alpha_out == $past(alpha_in, LATENCY))
    else $error("alpha not passed through");

  // zero alpha clears the colour channels
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && alpha_out == 8'd0) |-> (red_out == 8'd0 && green_out == 8'd0 &&
                                      blue_out == 8'd0))
    else $error("colour not zero at zero alpha");

  // full alpha leaves the blue channel unchanged for an ARGB source
  a_opaque: assert property (@(posedge clk) disable iff (rst)
    (strobe && alpha_out == FULL_SCALE && $past(layout, LATENCY) == LAYOUT_ARGB)
      |-> blue_out == $past(byte_three, LATENCY))
    else $error("opaque pixel colour changed");

endmodule

bind unpremultiply_alpha_pixel unpm_checker u_unpm_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .byte_zero  (byte_zero),
  .byte_three (byte_three),
  .cfg_we     (cfg_we),
  .cfg_data   (cfg_data),
  .strobe     (strobe),
  .red_out    (red_out),
  .green_out  (green_out),
  .blue_out   (blue_out),
  .alpha_out  (alpha_out)
);
